@@ rtl/sclk_pkg.sv @@
// package for the settable calendar clock
// payload structs, time struct, field step and event codes, calendar helper functions
// no dependencies
package sclk_pkg;

    localparam logic [11:0] YEAR_MIN        = 12'd2000;
    localparam logic [11:0] YEAR_MAX        = 12'd2099;
    localparam logic [11:0] YEAR_RESET      = 12'd2026;
    localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
    localparam logic [4:0]  HOURS_PER_DAY   = 5'd24;
    localparam logic [5:0]  MINUTES_PER_HR  = 6'd60;
    localparam logic [5:0]  SECONDS_PER_MIN = 6'd60;
    localparam logic [6:0]  CENTI_PER_SEC   = 7'd100;
    localparam logic [6:0]  YEAR_SPAN       = 7'd100;
    localparam logic [3:0]  TICKS_PER_CENTI = 4'd10;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;

    localparam logic [2:0] STEP_YEAR   = 3'd0;
    localparam logic [2:0] STEP_MONTH  = 3'd1;
    localparam logic [2:0] STEP_DAY    = 3'd2;
    localparam logic [2:0] STEP_HOUR   = 3'd3;
    localparam logic [2:0] STEP_MINUTE = 3'd4;
    localparam logic [2:0] STEP_SECOND = 3'd5;
    localparam logic [2:0] STEP_CENTI  = 3'd6;
    localparam logic [2:0] STEP_DONE   = 3'd7;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_SAMPLE  = 2'd1,
        FUNC_CONFIRM = 2'd2,
        FUNC_START   = 2'd3
    } t_func;

    typedef struct packed {
        t_func       func;
        logic [9:0]  adc_sample;
    } t_in_item;

    typedef struct packed {
        logic [11:0] year_now;
        logic [3:0]  month_now;
        logic [4:0]  day_now;
        logic [4:0]  hour_now;
        logic [5:0]  minute_now;
        logic [5:0]  second_now;
        logic [6:0]  centi_now;
        logic [2:0]  field_step;
        logic        is_running;
        logic        changed;
    } t_out_item;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [6:0]  centi;
    } t_time;

    // years stay inside 2000..2099, where the only century (2000) is a
    // multiple of 400, so the low two bits decide
    function automatic logic is_leap(input logic [11:0] year);
        return (year[1:0] == 2'b00);
    endfunction

    function automatic logic [4:0] month_len(input logic [11:0] year, input logic [3:0] month);
        logic [4:0] len;
        len = 5'd31;
        case (month)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB: len = is_leap(year) ? 5'd29 : 5'd28;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ rtl/sclk_scale.sv @@
// potentiometer scaler: maps a 10-bit sample onto the range of the field being set
// depends on sclk_pkg
module sclk_scale
    import sclk_pkg::*;
(
    input  logic [2:0]  i_step,
    input  logic [9:0]  i_sample,
    input  logic [11:0] i_year,
    input  logic [3:0]  i_month,
    output logic        o_ok,
    output logic [11:0] o_value
);

    logic [6:0]  count;
    logic [11:0] base;
    logic [16:0] product;

    always_comb begin
        o_ok  = 1'b1;
        count = YEAR_SPAN;
        base  = '0;
        case (i_step)
            STEP_YEAR: begin
                count = YEAR_SPAN;
                base  = YEAR_MIN;
            end
            STEP_MONTH: begin
                count = {3'b000, MONTHS_PER_YEAR};
                base  = 12'd1;
            end
            STEP_DAY: begin
                count = {2'b00, month_len(i_year, i_month)};
                base  = 12'd1;
            end
            STEP_HOUR:   count = {2'b00, HOURS_PER_DAY};
            STEP_MINUTE: count = {1'b0, MINUTES_PER_HR};
            STEP_SECOND: count = {1'b0, SECONDS_PER_MIN};
            STEP_CENTI:  count = CENTI_PER_SEC;
            default:     o_ok = 1'b0;
        endcase
    end

    // sample * count / 1024, the quotient fits in 7 bits
    assign product = {7'b0, i_sample} * {10'b0, count};
    assign o_value = base + {5'b0, product[16:10]};

endmodule

@@ rtl/sclk_advance.sv @@
// calendar carry chain: time one centisecond later
// depends on sclk_pkg
module sclk_advance
    import sclk_pkg::*;
(
    input  t_time i_time,
    output t_time o_time
);

    logic [4:0] month_days;

    assign month_days = month_len(i_time.year, i_time.month);

    always_comb begin
        o_time = i_time;
        if (i_time.centi < CENTI_PER_SEC - 7'd1) begin
            o_time.centi = i_time.centi + 7'd1;
        end else begin
            o_time.centi = '0;
            if (i_time.second < SECONDS_PER_MIN - 6'd1) begin
                o_time.second = i_time.second + 6'd1;
            end else begin
                o_time.second = '0;
                if (i_time.minute < MINUTES_PER_HR - 6'd1) begin
                    o_time.minute = i_time.minute + 6'd1;
                end else begin
                    o_time.minute = '0;
                    if (i_time.hour < HOURS_PER_DAY - 5'd1) begin
                        o_time.hour = i_time.hour + 5'd1;
                    end else begin
                        o_time.hour = '0;
                        if (i_time.day < month_days) begin
                            o_time.day = i_time.day + 5'd1;
                        end else begin
                            o_time.day = 5'd1;
                            if (i_time.month < MONTHS_PER_YEAR) begin
                                o_time.month = i_time.month + 4'd1;
                            end else begin
                                o_time.month = 4'd1;
                                // year wraps back to the start of the century
                                if (i_time.year >= YEAR_MAX) begin
                                    o_time.year = YEAR_MIN;
                                end else begin
                                    o_time.year = i_time.year + 12'd1;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

endmodule

@@ rtl/sclk_skid.sv @@
// two-entry output buffer: output register plus skid register
// depends on sclk_pkg
module sclk_skid
    import sclk_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_out_item i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_stall
);

    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_item r_out_data;
    t_out_item r_skid_data;
    logic      take;
    logic      put;

    assign take    = r_out_valid && !i_stall;
    assign put     = i_valid && !r_skid_valid;
    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid && take) begin
                r_skid_valid <= 1'b0;
            end else if (put && r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end
            if (r_skid_valid || put) begin
                r_out_valid <= 1'b1;
            end else if (take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid && take) begin
            r_out_data <= r_skid_data;
        end else if (put && (!r_out_valid || take)) begin
            r_out_data <= i_data;
        end
        if (put && r_out_valid && !take) begin
            r_skid_data <= i_data;
        end
    end

endmodule

@@ rtl/settable_calendar_clock.sv @@
// settable calendar clock, top level: state registers and event decode
// depends on sclk_pkg, sclk_scale, sclk_advance, sclk_skid
//
// usage:
//   input channel (i_in_valid / o_in_stall / i_in_data) carries one event per
//   transaction: millisecond tick, potentiometer sample, confirm field or start
//   output channel (o_out_valid / i_out_stall / o_out_data) returns exactly one
//   transaction per event: the full calendar time, the field being set, the run
//   flag and a changed flag
//   the result is registered: it enters the output register when the event is
//   taken, or the skid register while the output is held; throughput is one
//   event per cycle while o_in_stall is low; the whole event is decoded in one
//   pass of the scaler (one 10x7 multiply) and the carry chain into the state registers
//   a skid register behind the output register lets one more event in while the
//   receiver stalls; o_in_stall rises only once both are full
//   synchronous reset sets 2026-01-01 00:00:00.00, clock stopped, setting at the
//   year field, and empties the output buffer
//   the clock advances one centisecond every ten ticks while running
module settable_calendar_clock
    import sclk_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_time       r_time,       n_time;
    logic [3:0]  r_tick,       n_tick;
    logic [2:0]  r_step,       n_step;
    logic        r_run,        n_run;
    logic [11:0] r_last_value, n_last_value;
    logic        r_last_valid, n_last_valid;

    logic        in_acc;
    logic        changed;
    logic [3:0]  tick_inc;
    logic        scale_ok;
    logic [11:0] scale_value;
    t_time       adv_time;
    t_out_item   result;

    function automatic logic [4:0] clamp_day(input logic [4:0] day, input logic [4:0] last);
        logic [4:0] d;
        d = day;
        if (d > last) d = last;
        if (d < 5'd1) d = 5'd1;
        return d;
    endfunction

    sclk_scale u_scale (
        .i_step   (r_step),
        .i_sample (i_in_data.adc_sample),
        .i_year   (r_time.year),
        .i_month  (r_time.month),
        .o_ok     (scale_ok),
        .o_value  (scale_value)
    );

    sclk_advance u_advance (
        .i_time (r_time),
        .o_time (adv_time)
    );

    assign in_acc   = i_in_valid && !o_in_stall;
    assign tick_inc = r_tick + 4'd1;

    always_comb begin
        n_time       = r_time;
        n_tick       = r_tick;
        n_step       = r_step;
        n_run        = r_run;
        n_last_value = r_last_value;
        n_last_valid = r_last_valid;
        changed      = 1'b0;
        case (i_in_data.func)
            FUNC_TICK: begin
                if (!r_run) begin
                    n_tick = '0;
                end else if (tick_inc >= TICKS_PER_CENTI) begin
                    n_tick  = '0;
                    n_time  = adv_time;
                    changed = 1'b1;
                end else begin
                    n_tick = tick_inc;
                end
            end
            FUNC_SAMPLE: begin
                // a repeat of the last applied value is ignored
                if (scale_ok && !(r_last_valid && scale_value == r_last_value)) begin
                    case (r_step)
                        STEP_YEAR: begin
                            n_time.year = scale_value;
                            n_time.day  = clamp_day(r_time.day,
                                                    month_len(scale_value, r_time.month));
                        end
                        STEP_MONTH: begin
                            n_time.month = scale_value[3:0];
                            n_time.day   = clamp_day(r_time.day,
                                                     month_len(r_time.year, scale_value[3:0]));
                        end
                        STEP_DAY:    n_time.day    = scale_value[4:0];
                        STEP_HOUR:   n_time.hour   = scale_value[4:0];
                        STEP_MINUTE: n_time.minute = scale_value[5:0];
                        STEP_SECOND: n_time.second = scale_value[5:0];
                        default:     n_time.centi  = scale_value[6:0];
                    endcase
                    n_last_value = scale_value;
                    n_last_valid = 1'b1;
                    changed      = 1'b1;
                end
            end
            FUNC_CONFIRM: begin
                if (r_step != STEP_DONE) begin
                    n_step       = r_step + 3'd1;
                    n_last_valid = 1'b0;
                    if (r_step == STEP_DONE - 3'd1) n_run = 1'b0;
                    changed = 1'b1;
                end
            end
            default: begin
                if (r_step == STEP_DONE && !r_run) begin
                    n_run   = 1'b1;
                    changed = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time.year   <= YEAR_RESET;
            r_time.month  <= 4'd1;
            r_time.day    <= 5'd1;
            r_time.hour   <= '0;
            r_time.minute <= '0;
            r_time.second <= '0;
            r_time.centi  <= '0;
            r_tick        <= '0;
            r_step        <= STEP_YEAR;
            r_run         <= 1'b0;
            r_last_value  <= '0;
            r_last_valid  <= 1'b0;
        end else if (in_acc) begin
            r_time       <= n_time;
            r_tick       <= n_tick;
            r_step       <= n_step;
            r_run        <= n_run;
            r_last_value <= n_last_value;
            r_last_valid <= n_last_valid;
        end
    end

    always_comb begin
        result.year_now   = n_time.year;
        result.month_now  = n_time.month;
        result.day_now    = n_time.day;
        result.hour_now   = n_time.hour;
        result.minute_now = n_time.minute;
        result.second_now = n_time.second;
        result.centi_now  = n_time.centi;
        result.field_step = n_step;
        result.is_running = n_run;
        result.changed    = changed;
    end

    sclk_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (result),
        .o_stall (o_in_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

    // after an accept, the output holds a valid result on the next cycle
    a_accept_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted event produced no result");

    // input stalls only while a result is waiting at the output
    a_stall_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output register");

    // the clock can only be running once setting is finished
    a_run_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_step == STEP_DONE))
        else $error("clock running while a field is being set");

    // tick counter never reaches the centisecond divide
    a_tick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick < TICKS_PER_CENTI)
        else $error("tick counter out of range");

endmodule

@@ test/sclk_tb_pkg.sv @@
// scoreboard for the settable calendar clock testbench: predicts each reading
// from the accepted events and checks the readings returned by the block
// depends on sclk_pkg
`timescale 1ns / 1ps

package sclk_tb_pkg;
    import sclk_pkg::*;

    class cal_scoreboard;
        bit [11:0] year;
        bit [3:0]  month;
        bit [4:0]  day;
        bit [4:0]  hour;
        bit [5:0]  minute;
        bit [5:0]  second;
        bit [6:0]  centi;
        bit [3:0]  tick_cnt;
        bit [2:0]  step;
        bit        running;
        bit [11:0] last_set;
        bit        last_set_ok;

        t_out_item   expected_q[$];
        int unsigned errors;

        function new();
            year        = YEAR_RESET;
            month       = 4'd1;
            day         = 5'd1;
            hour        = '0;
            minute      = '0;
            second      = '0;
            centi       = '0;
            tick_cnt    = '0;
            step        = STEP_YEAR;
            running     = 1'b0;
            last_set    = '0;
            last_set_ok = 1'b0;
            errors      = 0;
        endfunction

        function int unsigned days_in_month();
            int unsigned y;
            bit          leap;
            y    = year;
            leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
            case (month)
                MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
                MONTH_FEB: return leap ? 29 : 28;
                default:   return 31;
            endcase
        endfunction

        function void clamp_day();
            int unsigned last;
            last = days_in_month();
            if (day > last) day = 5'(last);
            if (day == 0) day = 5'd1;
        endfunction

        // carry chain from centiseconds up to the year
        function void bump_centi();
            if (centi != CENTI_PER_SEC - 1) begin
                centi++;
                return;
            end
            centi = '0;
            if (second != SECONDS_PER_MIN - 1) begin
                second++;
                return;
            end
            second = '0;
            if (minute != MINUTES_PER_HR - 1) begin
                minute++;
                return;
            end
            minute = '0;
            if (hour != HOURS_PER_DAY - 1) begin
                hour++;
                return;
            end
            hour = '0;
            if (day < days_in_month()) begin
                day++;
                return;
            end
            day = 5'd1;
            if (month != MONTHS_PER_YEAR) begin
                month++;
                return;
            end
            month = 4'd1;
            if (year == YEAR_MAX) year = YEAR_MIN;
            else year++;
        endfunction

        // pot sample scaled to the field under setting, min + s*count/1024
        function bit apply_pot(bit [9:0] s);
            int unsigned sv;
            int unsigned v;
            sv = s;
            case (step)
                STEP_YEAR:   v = YEAR_MIN + (sv * YEAR_SPAN) / 1024;
                STEP_MONTH:  v = 1 + (sv * MONTHS_PER_YEAR) / 1024;
                STEP_DAY:    v = 1 + (sv * days_in_month()) / 1024;
                STEP_HOUR:   v = (sv * HOURS_PER_DAY) / 1024;
                STEP_MINUTE: v = (sv * MINUTES_PER_HR) / 1024;
                STEP_SECOND: v = (sv * SECONDS_PER_MIN) / 1024;
                STEP_CENTI:  v = (sv * CENTI_PER_SEC) / 1024;
                default:     return 1'b0;
            endcase
            if (last_set_ok && v[11:0] == last_set) return 1'b0;
            case (step)
                STEP_YEAR: begin
                    year = 12'(v);
                    clamp_day();
                end
                STEP_MONTH: begin
                    month = 4'(v);
                    clamp_day();
                end
                STEP_DAY:    day    = 5'(v);
                STEP_HOUR:   hour   = 5'(v);
                STEP_MINUTE: minute = 6'(v);
                STEP_SECOND: second = 6'(v);
                default:     centi  = 7'(v);
            endcase
            last_set    = v[11:0];
            last_set_ok = 1'b1;
            return 1'b1;
        endfunction

        function void note_event(t_in_item ev);
            t_out_item r;
            bit        changed;
            changed = 1'b0;
            case (ev.func)
                FUNC_TICK: begin
                    if (!running) begin
                        tick_cnt = '0;
                    end else begin
                        tick_cnt = tick_cnt + 4'd1;
                        if (tick_cnt >= TICKS_PER_CENTI) begin
                            tick_cnt = '0;
                            bump_centi();
                            changed = 1'b1;
                        end
                    end
                end
                FUNC_SAMPLE: changed = apply_pot(ev.adc_sample);
                FUNC_CONFIRM: begin
                    if (step != STEP_DONE) begin
                        step++;
                        last_set_ok = 1'b0;
                        if (step == STEP_DONE) running = 1'b0;
                        changed = 1'b1;
                    end
                end
                default: begin
                    if (step == STEP_DONE && !running) begin
                        running = 1'b1;
                        changed = 1'b1;
                    end
                end
            endcase
            r.year_now   = year;
            r.month_now  = month;
            r.day_now    = day;
            r.hour_now   = hour;
            r.minute_now = minute;
            r.second_now = second;
            r.centi_now  = centi;
            r.field_step = step;
            r.is_running = running;
            r.changed    = changed;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_reading(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected reading, expected none, actual %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("year_now",   want.year_now,   got.year_now);
            compare_field("month_now",  want.month_now,  got.month_now);
            compare_field("day_now",    want.day_now,    got.day_now);
            compare_field("hour_now",   want.hour_now,   got.hour_now);
            compare_field("minute_now", want.minute_now, got.minute_now);
            compare_field("second_now", want.second_now, got.second_now);
            compare_field("centi_now",  want.centi_now,  got.centi_now);
            compare_field("field_step", want.field_step, got.field_step);
            compare_field("is_running", want.is_running, got.is_running);
            compare_field("changed",    want.changed,    got.changed);
        endfunction
    endclass

endpackage

@@ test/tb_settable_calendar_clock.sv @@
// testbench top for the settable calendar clock: sets the clock once near a
// month end, runs it through the rollover and checks every reading
// depends on sclk_pkg, sclk_tb_pkg and the settable_calendar_clock rtl
`timescale 1ns / 1ps

module tb_settable_calendar_clock;
    import sclk_pkg::*;
    import sclk_tb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 40;
    localparam int RUN_TICKS   = 330;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    cal_scoreboard calendar_sb = new();

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_pending = 1'b0;
    bit hold_done    = 1'b0;
    int hold_left    = 0;
    int cycle_cnt    = 0;

    settable_calendar_clock dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_pending && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // signals only move at the rising edge, so the falling edge sees what
    // the next rising edge will take
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) calendar_sb.check_reading(o_out_data);
    end

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
    endtask

    // called at a rising edge, returns at the edge where the transaction is taken
    task automatic send_event(input t_func f, input logic [9:0] s);
        t_in_item ev;
        ev.func       = f;
        ev.adc_sample = s;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        forever begin
            @(negedge i_clk);
            if (!o_in_stall) break;
        end
        @(posedge i_clk);
        calendar_sb.note_event(ev);
    endtask

    initial begin
        logic [9:0] year_pick;
        logic [9:0] month_pick;
        int         ticks_sent;
        int         r;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_idling(20, 88);

        year_pick  = ($urandom_range(0, 3) == 0) ? 10'd1023 : 10'($urandom_range(0, 1023));
        case ($urandom_range(0, 3))
            0:       month_pick = 10'd1023;
            1:       month_pick = 10'd128;   // february
            default: month_pick = 10'($urandom_range(0, 1023));
        endcase

        // setting: extremes of year, month, centi, then park before a month end
        send_event(FUNC_TICK, 10'd0);
        send_event(FUNC_START, 10'd0);
        send_event(FUNC_SAMPLE, 10'd0);
        send_event(FUNC_SAMPLE, 10'd0);
        send_event(FUNC_SAMPLE, 10'd1023);
        send_event(FUNC_SAMPLE, year_pick);
        send_event(FUNC_CONFIRM, 10'd0);
        send_event(FUNC_SAMPLE, 10'd1023);
        send_event(FUNC_SAMPLE, 10'd0);
        send_event(FUNC_SAMPLE, month_pick);
        send_event(FUNC_CONFIRM, 10'd0);
        send_event(FUNC_SAMPLE, 10'd1023);
        send_event(FUNC_CONFIRM, 10'd0);
        send_event(FUNC_SAMPLE, 10'd1023);
        send_event(FUNC_CONFIRM, 10'd0);
        send_event(FUNC_SAMPLE, 10'd1023);
        send_event(FUNC_CONFIRM, 10'd0);
        send_event(FUNC_SAMPLE, 10'd1023);
        send_event(FUNC_CONFIRM, 10'd0);
        send_event(FUNC_SAMPLE, 10'd0);
        send_event(FUNC_SAMPLE, 10'd1023);
        send_event(FUNC_TICK, 10'd1023);
        send_event(FUNC_CONFIRM, 10'd0);
        // last centisecond of a month, so the first carry ripples into the month
        send_event(FUNC_SAMPLE, 10'd1023);
        send_event(FUNC_CONFIRM, 10'd0);
        send_event(FUNC_START, 10'd0);
        send_event(FUNC_START, 10'd0);

        // running: mostly ticks, with stray samples, confirms and starts
        ticks_sent = 0;
        while (ticks_sent < RUN_TICKS) begin
            if (ticks_sent == RUN_TICKS / 3) begin
                set_idling(88, 20);
            end else if (ticks_sent == 2 * RUN_TICKS / 3) begin
                set_idling(0, 0);
                hold_pending <= 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 88) begin
                send_event(FUNC_TICK, 10'($urandom_range(0, 1023)));
                ticks_sent++;
            end else begin
                send_event(t_func'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)));
            end
        end
        i_in_valid <= 1'b0;

        while (calendar_sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (calendar_sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/sclk_pkg.sv
rtl/sclk_scale.sv
rtl/sclk_advance.sv
rtl/sclk_skid.sv
rtl/settable_calendar_clock.sv
test/sclk_tb_pkg.sv
test/tb_settable_calendar_clock.sv
